FILE: sv/encoder_pi_speed_controller_assert.svh
// Assertion macros used by the speed controller checker.
`ifndef ENCODER_PI_SPEED_CONTROLLER_ASSERT_SVH
`define ENCODER_PI_SPEED_CONTROLLER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define EPSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define EPSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/epsc_pkg.sv
// Shared constants and types of the encoder speed controller.
`default_nettype none

package epsc_pkg;

  localparam int INTEGRAL_WIDTH = 40;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = 24;
  localparam int COUNT_W        = 16;
  localparam int POS_W          = 32;
  localparam int CODE_W         = 16;
  localparam int ERR_LOW_W      = CODE_W - 4;
  localparam int SPEED_LOW_W    = CODE_W - 8;

  localparam int MUL_MAG_W      = INTEGRAL_WIDTH;
  localparam int MUL_PROD_W     = MUL_MAG_W + GAIN_W - GAIN_FRAC_BITS;
  localparam int MUL_CNT_W      = $clog2(GAIN_W);
  localparam int E_MAG_W        = COUNT_W + GAIN_W - GAIN_FRAC_BITS;
  localparam int U_W            = MUL_PROD_W + 2;

  localparam int IN_TDATA_W     = 2 * COUNT_W;
  localparam int OUT_FIELDS_W   = 3 * CODE_W + POS_W + 1;
  localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W      = OUT_TDATA_W - OUT_FIELDS_W;

  localparam int CFG_ADDR_W     = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_MODE          = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_P_ONLY_GAIN   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ERROR_SCALE   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PROP_GAIN     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_INTEGRAL_GAIN = 3'd4;

  localparam logic              MODE_RST          = 1'b1;
  localparam logic [GAIN_W-1:0] P_ONLY_GAIN_RST   = 24'd2850816;
  localparam logic [GAIN_W-1:0] ERROR_SCALE_RST   = 24'd205881;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST     = 24'd686189;
  localparam logic [GAIN_W-1:0] INTEGRAL_GAIN_RST = 24'd79555;

  localparam logic [CODE_W-1:0] DRIVE_LIMIT     = 16'h7FFF;
  localparam logic [CODE_W-1:0] DAC_ZERO        = 16'h8000;
  localparam logic [CODE_W-1:0] DRIVE_CODE_HIGH = 16'hFFFF;
  localparam logic [CODE_W-1:0] DRIVE_CODE_LOW  = 16'h0001;

  localparam logic [INTEGRAL_WIDTH-1:0] INTEGRAL_MAX = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
  localparam logic [INTEGRAL_WIDTH-1:0] INTEGRAL_MIN = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic                 start;
    logic [MUL_MAG_W-1:0] mag;
    logic [GAIN_W-1:0]    gain;
  } epsc_mul_req_t;

  typedef struct packed {
    logic                  done;
    logic [MUL_PROD_W-1:0] prod;
  } epsc_mul_rsp_t;

endpackage

`default_nettype wire

FILE: sv/epsc_sermul.sv
// Bit-serial shift-add multiplier of a magnitude by an unsigned fixed-point gain.
`default_nettype none

module epsc_sermul import epsc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  epsc_mul_req_t mul_req,
  output epsc_mul_rsp_t mul_rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [MUL_MAG_W-1:0] mag_r;
  logic [GAIN_W-1:0]    gain_r;
  logic [MUL_MAG_W-1:0] hi_r;
  logic [GAIN_W-1:0]    lo_r;
  logic [MUL_MAG_W:0]   sum;

  assign sum = {1'b0, hi_r} + (gain_r[0] ? {1'b0, mag_r} : {(MUL_MAG_W+1){1'b0}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (mul_req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        mag_r  <= mul_req.mag;
        gain_r <= mul_req.gain;
        hi_r   <= '0;
        lo_r   <= '0;
      end else if (busy_r) begin
        hi_r   <= sum[MUL_MAG_W:1];
        lo_r   <= {sum[0], lo_r[GAIN_W-1:1]};
        gain_r <= gain_r >> 1;
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == MUL_CNT_W'(GAIN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign mul_rsp.done = done_r;
  assign mul_rsp.prod = {hi_r, lo_r[GAIN_W-1:GAIN_FRAC_BITS]};

endmodule

`default_nettype wire

FILE: sv/encoder_pi_speed_controller.sv
// Encoder speed measurement with P or PI control and offset DAC code outputs.
// in_tready is high only in the idle state: a new request is not taken until the result of the
// previous one has been placed in the output register. Each product takes 24 multiplier steps;
// PI mode computes three products in turn (error scale, proportional, integral), P mode one.
// Synchronous active-low reset clears the state, the integral and the registers to defaults.
`default_nettype none

module encoder_pi_speed_controller import epsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [GAIN_W-1:0]      cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // encoder_count[15:0], speed_setpoint[31:16]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // drive_code[15:0], error_code[31:16], speed_code[47:32], position[79:48],
  // drive_saturated[80], zero padding above.
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_E,
    S_INTEG,
    S_MUL_P,
    S_MUL_I,
    S_DONE
  } state_t;

  logic              mode_r;
  logic [GAIN_W-1:0] p_only_gain_r;
  logic [GAIN_W-1:0] error_scale_r;
  logic [GAIN_W-1:0] prop_gain_r;
  logic [GAIN_W-1:0] integral_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_RST;
      p_only_gain_r   <= P_ONLY_GAIN_RST;
      error_scale_r   <= ERROR_SCALE_RST;
      prop_gain_r     <= PROP_GAIN_RST;
      integral_gain_r <= INTEGRAL_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MODE:          mode_r          <= cfg_wdata[0];
        CFG_P_ONLY_GAIN:   p_only_gain_r   <= cfg_wdata;
        CFG_ERROR_SCALE:   error_scale_r   <= cfg_wdata;
        CFG_PROP_GAIN:     prop_gain_r     <= cfg_wdata;
        CFG_INTEGRAL_GAIN: integral_gain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  state_t                   state_r, state_nxt;
  logic [COUNT_W-1:0]       last_count_r, last_count_nxt;
  logic [POS_W-1:0]         position_r, position_nxt;
  logic [INTEGRAL_WIDTH-1:0] integral_r, integral_nxt;
  logic [COUNT_W-1:0]       speed_r, speed_nxt;
  logic                     d_neg_r, d_neg_nxt;
  logic [E_MAG_W-1:0]       e_mag_r, e_mag_nxt;
  logic                     e_neg_r, e_neg_nxt;
  logic [ERR_LOW_W-1:0]     e_low_r, e_low_nxt;
  logic [U_W-1:0]           u_r, u_nxt;
  logic                     term_neg_r, term_neg_nxt;
  epsc_mul_req_t            req_r, req_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]   out_tdata_r, out_tdata_nxt;
  epsc_mul_rsp_t            mul_rsp;

  logic [COUNT_W-1:0]        enc_count;
  logic [COUNT_W-1:0]        setpoint;
  logic [COUNT_W-1:0]        diff;
  logic [COUNT_W:0]          d_full;
  logic [COUNT_W:0]          d_abs;
  logic [U_W-1:0]            term_ext;
  logic [U_W-1:0]            u_acc;
  logic [INTEGRAL_WIDTH:0]   integ_sum;
  logic [INTEGRAL_WIDTH-1:0] integ_abs;
  logic                      sat_pos;
  logic                      sat_neg;
  logic [CODE_W-1:0]         drive_val;

  epsc_sermul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .mul_req (req_r),
    .mul_rsp (mul_rsp)
  );

  assign enc_count = in_tdata[COUNT_W-1:0];
  assign setpoint  = in_tdata[IN_TDATA_W-1:COUNT_W];
  assign diff      = enc_count - last_count_r;
  assign d_full    = {setpoint[COUNT_W-1], setpoint} - {diff[COUNT_W-1], diff};
  assign d_abs     = d_full[COUNT_W] ? (~d_full + 1'b1) : d_full;

  assign term_ext  = U_W'(mul_rsp.prod);
  assign u_acc     = u_r + (term_ext ^ {U_W{term_neg_r}}) + U_W'(term_neg_r);

  assign integ_sum = {integral_r[INTEGRAL_WIDTH-1], integral_r}
                   + ((INTEGRAL_WIDTH+1)'(e_mag_r) ^ {(INTEGRAL_WIDTH+1){e_neg_r}})
                   + (INTEGRAL_WIDTH+1)'(e_neg_r);
  assign integ_abs = integral_r[INTEGRAL_WIDTH-1] ? (~integral_r + 1'b1) : integral_r;

  assign sat_pos   = $signed(u_r) >= $signed(U_W'(DRIVE_LIMIT));
  assign sat_neg   = $signed(u_r) <= -$signed(U_W'(DRIVE_LIMIT));
  assign drive_val = sat_pos ? DRIVE_LIMIT : (sat_neg ? (~DRIVE_LIMIT + 1'b1) : u_r[CODE_W-1:0]);

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    last_count_nxt = last_count_r;
    position_nxt   = position_r;
    integral_nxt   = integral_r;
    speed_nxt      = speed_r;
    d_neg_nxt      = d_neg_r;
    e_mag_nxt      = e_mag_r;
    e_neg_nxt      = e_neg_r;
    e_low_nxt      = e_low_r;
    u_nxt          = u_r;
    term_neg_nxt   = term_neg_r;
    req_nxt        = req_r;
    req_nxt.start  = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          last_count_nxt = enc_count;
          position_nxt   = position_r + {{(POS_W-COUNT_W){diff[COUNT_W-1]}}, diff};
          speed_nxt      = diff;
          d_neg_nxt      = d_full[COUNT_W];
          e_low_nxt      = d_full[ERR_LOW_W-1:0];
          u_nxt          = '0;
          term_neg_nxt   = d_full[COUNT_W];
          req_nxt.start  = 1'b1;
          req_nxt.mag    = MUL_MAG_W'(d_abs[COUNT_W-1:0]);
          req_nxt.gain   = mode_r ? error_scale_r : p_only_gain_r;
          state_nxt      = mode_r ? S_MUL_E : S_MUL_P;
        end
      end
      S_MUL_E: begin
        if (mul_rsp.done) begin
          e_mag_nxt = mul_rsp.prod[E_MAG_W-1:0];
          e_neg_nxt = d_neg_r && (mul_rsp.prod[E_MAG_W-1:0] != '0);
          e_low_nxt = d_neg_r ? (~mul_rsp.prod[ERR_LOW_W-1:0] + 1'b1)
                              : mul_rsp.prod[ERR_LOW_W-1:0];
          state_nxt = S_INTEG;
        end
      end
      S_INTEG: begin
        if (integ_sum[INTEGRAL_WIDTH] != integ_sum[INTEGRAL_WIDTH-1]) begin
          integral_nxt = integ_sum[INTEGRAL_WIDTH] ? INTEGRAL_MIN : INTEGRAL_MAX;
        end else begin
          integral_nxt = integ_sum[INTEGRAL_WIDTH-1:0];
        end
        term_neg_nxt  = e_neg_r;
        req_nxt.start = 1'b1;
        req_nxt.mag   = MUL_MAG_W'(e_mag_r);
        req_nxt.gain  = prop_gain_r;
        state_nxt     = S_MUL_P;
      end
      S_MUL_P: begin
        if (mul_rsp.done) begin
          u_nxt = u_acc;
          if (mode_r) begin
            term_neg_nxt  = integral_r[INTEGRAL_WIDTH-1];
            req_nxt.start = 1'b1;
            req_nxt.mag   = integ_abs;
            req_nxt.gain  = integral_gain_r;
            state_nxt     = S_MUL_I;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MUL_I: begin
        if (mul_rsp.done) begin
          u_nxt     = u_acc;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{OUT_PAD_W{1'b0}},
                            sat_pos || sat_neg,
                            position_r,
                            {speed_r[SPEED_LOW_W-1:0], {(CODE_W-SPEED_LOW_W){1'b0}}} ^ DAC_ZERO,
                            {e_low_r, {(CODE_W-ERR_LOW_W){1'b0}}} ^ DAC_ZERO,
                            drive_val ^ DAC_ZERO};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      last_count_r  <= '0;
      position_r    <= '0;
      integral_r    <= '0;
      req_r.start   <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      last_count_r  <= last_count_nxt;
      position_r    <= position_nxt;
      integral_r    <= integral_nxt;
      req_r.start   <= req_nxt.start;
      out_tvalid_r  <= out_tvalid_nxt;
    end
    req_r.mag   <= req_nxt.mag;
    req_r.gain  <= req_nxt.gain;
    speed_r     <= speed_nxt;
    d_neg_r     <= d_neg_nxt;
    e_mag_r     <= e_mag_nxt;
    e_neg_r     <= e_neg_nxt;
    e_low_r     <= e_low_nxt;
    u_r         <= u_nxt;
    term_neg_r  <= term_neg_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

FILE: sv/epsc_checker.sv
// Port-level assertion checker for the speed controller, bound to the top level.
`default_nettype none
`include "encoder_pi_speed_controller_assert.svh"

module epsc_checker import epsc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `EPSC_ASSERT_NEXT(a_out_valid_held, out_tvalid && !out_tready, out_tvalid, "result request dropped while stalled")
  `EPSC_ASSERT_NEXT(a_out_data_held, out_tvalid && !out_tready, $stable(out_tdata), "result data changed while stalled")
  `EPSC_ASSERT_SAME(a_sat_code, out_tvalid && out_tdata[3*CODE_W+POS_W], (out_tdata[CODE_W-1:0] == DRIVE_CODE_HIGH) || (out_tdata[CODE_W-1:0] == DRIVE_CODE_LOW), "saturated drive is not at a clamp code")
  `EPSC_ASSERT_SAME(a_code_low_bits, out_tvalid, (out_tdata[CODE_W+3:CODE_W] == 4'h0) && (out_tdata[2*CODE_W+7:2*CODE_W] == 8'h00), "error or speed code has nonzero shifted-in bits")
  `EPSC_ASSERT_SAME(a_pad_zero, out_tvalid, out_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] == '0, "result padding is not zero")

endmodule

bind encoder_pi_speed_controller epsc_checker u_epsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

FILE: tb/encoder_pi_speed_controller_test.sv
// Self-checking testbench of the encoder speed controller with its own PI prediction.
module encoder_pi_speed_controller_test import epsc_pkg::*; ();

  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int REPORT_LIMIT = 10;
  localparam int SETTLE_CYCLES = 100;
  localparam logic MODE_P = 1'b0;
  localparam logic MODE_PI = 1'b1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC_BITS);
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  localparam logic [127:0] PRODUCT_CAP = 128'd1 << 48;
  localparam longint INTEG_HI = longint'(INTEGRAL_MAX);
  localparam longint INTEG_LO = -INTEG_HI - 1;
  localparam longint DRIVE_MAX = longint'(DRIVE_LIMIT);

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic signed [COUNT_W-1:0] setpoint;
  } tick_t;

  typedef struct packed {
    logic [CODE_W-1:0] drive_code;
    logic [CODE_W-1:0] error_code;
    logic [CODE_W-1:0] speed_code;
    logic [POS_W-1:0] position;
    logic saturated;
  } dac_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [GAIN_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Register copies and controller state as the block should hold them.
  logic ctl_mode = MODE_RST;
  logic [GAIN_W-1:0] p_gain = P_ONLY_GAIN_RST;
  logic [GAIN_W-1:0] err_scale = ERROR_SCALE_RST;
  logic [GAIN_W-1:0] kp_gain = PROP_GAIN_RST;
  logic [GAIN_W-1:0] ki_gain = INTEGRAL_GAIN_RST;
  logic [COUNT_W-1:0] prev_count = '0;
  logic [POS_W-1:0] pos_acc = '0;
  longint integ = 0;

  tick_t sample_q[$];
  dac_frame_t frame_q[$];
  tick_t next_sample;
  dac_frame_t want;
  dac_frame_t got;
  logic [COUNT_W-1:0] stim_last = '0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  encoder_pi_speed_controller u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint scaled_product(input longint value, input logic [GAIN_W-1:0] gain);
    logic [127:0] mag;
    logic [127:0] prod;
    mag = (value < 0) ? 128'(-value) : 128'(value);
    prod = (mag * gain) >> GAIN_FRAC_BITS;
    if (prod > PRODUCT_CAP) prod = PRODUCT_CAP;
    return (value < 0) ? -longint'(prod[62:0]) : longint'(prod[62:0]);
  endfunction

  function automatic dac_frame_t predict_tick(input logic [COUNT_W-1:0] count,
                                              input logic signed [COUNT_W-1:0] setpoint);
    logic [COUNT_W-1:0] diff;
    longint speed;
    longint d;
    longint e;
    longint u;
    dac_frame_t r;
    diff = count - prev_count;
    speed = longint'($signed(diff));
    prev_count = count;
    pos_acc = pos_acc + speed[POS_W-1:0];
    d = longint'(setpoint) - speed;
    if (ctl_mode == MODE_P) begin
      e = d;
      u = scaled_product(e, p_gain);
    end else begin
      e = scaled_product(d, err_scale);
      if (e > 0 && integ > INTEG_HI - e) integ = INTEG_HI;
      else if (e < 0 && integ < INTEG_LO - e) integ = INTEG_LO;
      else integ = integ + e;
      u = scaled_product(e, kp_gain) + scaled_product(integ, ki_gain);
    end
    r.saturated = 1'b0;
    if (u >= DRIVE_MAX) begin
      u = DRIVE_MAX;
      r.saturated = 1'b1;
    end
    if (u <= -DRIVE_MAX) begin
      u = -DRIVE_MAX;
      r.saturated = 1'b1;
    end
    r.drive_code = u[CODE_W-1:0] + DAC_ZERO;
    r.error_code = {e[ERR_LOW_W-1:0], 4'b0} + DAC_ZERO;
    r.speed_code = {speed[SPEED_LOW_W-1:0], 8'b0} + DAC_ZERO;
    r.position = pos_acc;
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL encoder_pi_speed_controller");
      $finish;
    end
  end

  // A request stays up until it is taken; idle gaps only start on a free slot.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        frame_q.push_back(predict_tick(in_tdata[COUNT_W-1:0], in_tdata[2*COUNT_W-1:COUNT_W]));
      end
      if (!in_tvalid || in_tready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_sample = sample_q.pop_front();
          in_tdata <= {next_sample.setpoint, next_sample.count};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.drive_code = out_tdata[CODE_W-1:0];
        got.error_code = out_tdata[2*CODE_W-1:CODE_W];
        got.speed_code = out_tdata[3*CODE_W-1:2*CODE_W];
        got.position = out_tdata[3*CODE_W+POS_W-1:3*CODE_W];
        got.saturated = out_tdata[3*CODE_W+POS_W];
        if (frame_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("Result with no request pending: tdata %h", out_tdata);
        end else begin
          want = frame_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("Mismatch expected drive %h error %h speed %h pos %h sat %b",
                       want.drive_code, want.error_code, want.speed_code, want.position,
                       want.saturated);
              $display("         actual   drive %h error %h speed %h pos %h sat %b",
                       got.drive_code, got.error_code, got.speed_code, got.position,
                       got.saturated);
            end
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [GAIN_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_MODE: ctl_mode = value[0];
      CFG_P_ONLY_GAIN: p_gain = value;
      CFG_ERROR_SCALE: err_scale = value;
      CFG_PROP_GAIN: kp_gain = value;
      CFG_INTEGRAL_GAIN: ki_gain = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_tick(input logic [COUNT_W-1:0] count, input logic [COUNT_W-1:0] setpoint);
    tick_t t;
    t.count = count;
    t.setpoint = setpoint;
    sample_q.push_back(t);
    stim_last = count;
  endtask

  task automatic push_speed(input int speed, input int setpoint);
    push_tick(stim_last + COUNT_W'(speed), COUNT_W'(setpoint));
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_tvalid || frame_q.size() != 0) @(negedge clk);
  endtask

  task automatic randomize_config();
    logic [GAIN_W-1:0] pick;
    int idx;
    write_reg(CFG_MODE, GAIN_W'($urandom));
    for (idx = int'(CFG_P_ONLY_GAIN); idx <= int'(CFG_INTEGRAL_GAIN); idx++) begin
      case ($urandom_range(3))
        0: pick = GAIN_W'($urandom_range(1 << 18));
        1: pick = GAIN_W'($urandom);
        2: pick = $urandom_range(1) ? GAIN_MAX : '0;
        default: begin
          case (CFG_ADDR_W'(idx))
            CFG_P_ONLY_GAIN: pick = P_ONLY_GAIN_RST;
            CFG_ERROR_SCALE: pick = ERROR_SCALE_RST;
            CFG_PROP_GAIN: pick = PROP_GAIN_RST;
            default: pick = INTEGRAL_GAIN_RST;
          endcase
        end
      endcase
      write_reg(CFG_ADDR_W'(idx), pick);
    end
    if ($urandom_range(3) == 0)
      write_reg(CFG_ADDR_W'($urandom_range((1 << CFG_ADDR_W) - 1, CFG_INTEGRAL_GAIN + 1)),
                GAIN_W'($urandom));
  endtask

  task automatic random_ticks(input int n);
    int i;
    int step;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          step = int'($urandom_range(600)) - 300;
          push_speed(step, step + int'($urandom_range(64)) - 32);
        end
        6, 7: push_tick(COUNT_W'($urandom), COUNT_W'($urandom));
        default: begin
          step = int'($signed(COUNT_W'($urandom)));
          push_speed(step, step + int'($urandom_range(16)) - 8);
        end
      endcase
    end
  endtask

  initial begin
    int phase;
    int send_pct[4];
    int recv_pct[4];
    send_pct = '{0, 57, 0, 16};
    recv_pct = '{0, 0, 57, 16};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_MODE, GAIN_W'(MODE_P));
    write_reg(CFG_P_ONLY_GAIN, GAIN_ONE);
    push_speed(0, 0);
    push_speed(0, 32767);
    push_speed(0, -32767);
    push_speed(0, 32766);
    push_speed(0, -32768);
    push_speed(32767, -32768);
    push_speed(-32768, 32767);
    push_speed(-1, 1);
    push_speed(1, -1);
    push_tick(16'hFFFF, '0);
    push_tick(16'h0000, '0);
    wait_drained();
    write_reg(CFG_P_ONLY_GAIN, GAIN_MAX);
    push_speed(100, -100);
    push_speed(0, 100);
    wait_drained();
    write_reg(CFG_MODE, GAIN_W'(MODE_PI));
    write_reg(CFG_ERROR_SCALE, GAIN_MAX);
    write_reg(CFG_PROP_GAIN, GAIN_MAX);
    write_reg(CFG_INTEGRAL_GAIN, GAIN_MAX);
    push_speed(-32768, 32767);
    push_speed(32767, -32768);
    push_speed(0, 1);
    wait_drained();
    write_reg(CFG_ERROR_SCALE, '0);
    write_reg(CFG_PROP_GAIN, '0);
    write_reg(CFG_INTEGRAL_GAIN, '0);
    push_speed(5, -5);
    wait_drained();
    write_reg(CFG_ADDR_W'(CFG_INTEGRAL_GAIN + 1), GAIN_MAX);
    write_reg(CFG_ADDR_W'((1 << CFG_ADDR_W) - 1), GAIN_ONE);
    write_reg(CFG_ERROR_SCALE, ERROR_SCALE_RST);
    write_reg(CFG_PROP_GAIN, PROP_GAIN_RST);
    write_reg(CFG_INTEGRAL_GAIN, INTEGRAL_GAIN_RST);
    push_speed(10, 20);
    push_speed(-10, -20);
    wait_drained();
    write_reg(CFG_MODE, GAIN_W'(MODE_P));
    write_reg(CFG_P_ONLY_GAIN, '0);
    push_speed(300, -300);

    for (phase = 0; phase < 8; phase++) begin
      wait_drained();
      randomize_config();
      send_idle_pct = send_pct[phase % 4];
      recv_stall_pct = recv_pct[phase % 4];
      random_ticks(72);
    end

    // Push the integral up hard with the largest error per tick, then reverse it.
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_MODE, GAIN_W'(MODE_PI));
    write_reg(CFG_ERROR_SCALE, GAIN_MAX);
    write_reg(CFG_PROP_GAIN, GAIN_W'($urandom));
    write_reg(CFG_INTEGRAL_GAIN, GAIN_W'($urandom_range(1 << 12)));
    repeat (30) push_speed(-32768, 32767);
    repeat (6) push_speed(32767, -32768);
    wait_drained();
    write_reg(CFG_MODE, GAIN_W'(MODE_P));
    random_ticks(8);
    wait_drained();
    write_reg(CFG_MODE, GAIN_W'(MODE_PI));
    random_ticks(8);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && frame_q.size() == 0) begin
      $display("PASS encoder_pi_speed_controller");
    end else begin
      $display("FAIL encoder_pi_speed_controller");
    end
    $finish;
  end

endmodule
